### rtl/dbar_pkg.sv
// Package for the DRAM bank address remap block.
// Holds size and status codes, register indexes, the configuration struct
// and the size and line-mask helper functions. Depends on nothing.
package dbar_pkg;

   localparam int AddrWidth      = 24;
   localparam int MapWidth       = 22;
   localparam int OffsetWidth    = 23;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 23;
   localparam int RspDataWidth   = 24;

   localparam logic [AddrWidth-1:0]   WindowTop    = 24'h40_0000;
   localparam logic [OffsetWidth-1:0] InstalledRst = 23'h40_0000;

   typedef enum logic [1:0] {
      SIZE_128K = 2'd0,
      SIZE_512K = 2'd1,
      SIZE_2M   = 2'd2,
      SIZE_NONE = 2'd3
   } size_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BUS_ERR = 2'd1,
      STATUS_GAP     = 2'd2,
      STATUS_PAST    = 2'd3
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CTRL_BANK0 = 3'd0,
      CSR_CTRL_BANK1 = 3'd1,
      CSR_RAM_BANK0  = 3'd2,
      CSR_RAM_BANK1  = 3'd3,
      CSR_EARLY      = 3'd4,
      CSR_INSTALLED  = 3'd5
   } csr_index_type;

   typedef struct packed {
      size_type                 ctrl_bank0_size;
      size_type                 ctrl_bank1_size;
      size_type                 ram_bank0_size;
      size_type                 ram_bank1_size;
      logic                     early_model_decoding;
      logic [OffsetWidth-1:0]   installed_bytes;
   } cfg_type;

   function automatic logic [OffsetWidth-1:0] size_bytes(input size_type code);
      logic [OffsetWidth-1:0] bytes;
      unique case (code)
         SIZE_128K: bytes = 23'h02_0000;
         SIZE_512K: bytes = 23'h08_0000;
         SIZE_2M:   bytes = 23'h20_0000;
         default:   bytes = '0;
      endcase
      return bytes;
   endfunction

   // Row and column lines missing on the fitted chips.
   function automatic logic [OffsetWidth-1:0] line_mask(input size_type ctrl,
                                                        input size_type ram,
                                                        input logic early);
      logic [OffsetWidth-1:0] mask;
      mask = '0;
      if (ctrl == SIZE_2M && ram == SIZE_512K) begin
         mask = early ? ((23'd1 << 20) | (23'd1 << 10))
                      : ((23'd1 << 20) | (23'd1 << 19));
      end else if (ctrl == SIZE_2M && ram == SIZE_128K) begin
         mask = early ? ((23'd1 << 20) | (23'd1 << 19) | (23'd1 << 10) | (23'd1 << 9))
                      : ((23'd1 << 20) | (23'd1 << 19) | (23'd1 << 18) | (23'd1 << 17));
      end else if (ctrl == SIZE_512K && ram == SIZE_128K) begin
         mask = early ? ((23'd1 << 18) | (23'd1 << 9))
                      : ((23'd1 << 18) | (23'd1 << 17));
      end
      return mask;
   endfunction

endpackage

### rtl/dbar_csr.sv
// Configuration registers of the DRAM bank address remap block.
// Depends on dbar_pkg for the register indexes and the cfg_type struct.
module dbar_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbar_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dbar_pkg::CsrDataWidth-1:0]    csr_data,
   output dbar_pkg::cfg_type                    cfg
);
   import dbar_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CTRL_BANK0: cfg_in.ctrl_bank0_size      = size_type'(csr_data[1:0]);
            CSR_CTRL_BANK1: cfg_in.ctrl_bank1_size      = size_type'(csr_data[1:0]);
            CSR_RAM_BANK0:  cfg_in.ram_bank0_size       = size_type'(csr_data[1:0]);
            CSR_RAM_BANK1:  cfg_in.ram_bank1_size       = size_type'(csr_data[1:0]);
            CSR_EARLY:      cfg_in.early_model_decoding = csr_data[0];
            CSR_INSTALLED:  cfg_in.installed_bytes      = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ctrl_bank0_size      <= SIZE_2M;
         cfg_ff.ctrl_bank1_size      <= SIZE_2M;
         cfg_ff.ram_bank0_size       <= SIZE_2M;
         cfg_ff.ram_bank1_size       <= SIZE_2M;
         cfg_ff.early_model_decoding <= 1'b1;
         cfg_ff.installed_bytes      <= InstalledRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/dbar_remap.sv
// Combinational address translation: window check, bank select, line masking,
// bank 1 rebase and installed-memory check. Depends on dbar_pkg.
module dbar_remap (
   input  logic [dbar_pkg::AddrWidth-1:0]  cpu_address,
   input  dbar_pkg::cfg_type               cfg,
   output logic [dbar_pkg::MapWidth-1:0]   mapped_address,
   output dbar_pkg::status_type            map_status
);
   import dbar_pkg::*;

   logic [OffsetWidth-1:0] size0;
   logic [OffsetWidth-1:0] size1;
   logic [OffsetWidth-1:0] ram0_bytes;
   logic [OffsetWidth-1:0] addr_low;
   logic [OffsetWidth-1:0] offset1;
   logic [OffsetWidth-1:0] offset;
   logic [OffsetWidth-1:0] masked;
   logic [OffsetWidth-1:0] rebased;
   logic                   bus_err;
   logic                   second;
   size_type               ctrl_sel;
   size_type               ram_sel;

   always_comb begin
      size0      = size_bytes(cfg.ctrl_bank0_size);
      size1      = size_bytes(cfg.ctrl_bank1_size);
      ram0_bytes = size_bytes(cfg.ram_bank0_size);
      bus_err    = cpu_address > WindowTop;
      addr_low   = cpu_address[OffsetWidth-1:0];
      second     = addr_low >= size0;
      offset1    = addr_low - size0;
      offset     = second ? offset1 : addr_low;
      ctrl_sel   = second ? cfg.ctrl_bank1_size : cfg.ctrl_bank0_size;
      ram_sel    = second ? cfg.ram_bank1_size  : cfg.ram_bank0_size;
      masked     = offset & ~line_mask(ctrl_sel, ram_sel, cfg.early_model_decoding);
      rebased    = second ? masked + ram0_bytes : masked;

      if (bus_err) begin
         map_status = STATUS_BUS_ERR;
      end else if (second && offset1 >= size1) begin
         map_status = STATUS_GAP;
      end else if (ram_sel == SIZE_NONE) begin
         map_status = STATUS_GAP;
      end else if (rebased >= cfg.installed_bytes) begin
         map_status = STATUS_PAST;
      end else begin
         map_status = STATUS_OK;
      end

      mapped_address = (map_status == STATUS_OK) ? rebased[MapWidth-1:0] : '0;
   end

endmodule

### rtl/dram_bank_address_remap_top.sv
// Top level of the DRAM bank address remap block.
// Depends on dbar_pkg, dbar_csr and dbar_remap.
//
// Usage:
//   req_ channel: one 24-bit CPU byte address per item in req_tdata.
//   rsp_ channel: one result per item, mapped address in rsp_tdata and the
//   status code in rsp_tuser (ok, bus error, gap, past installed memory).
//   csr_ channel: register writes by index; always ready.
//   Write registers only while no item is in flight.
// Path: each address is captured in the input register, translated combinationally
// and captured in the result register, which drives rsp_tvalid and the result.
// Throughput: one item per cycle while rsp_tready is high, set by the single-pass
// translation between the two registers.
// Reset: synchronous, active high; both stages empty, registers return to
// 2 MiB banks, early-model masking and 4 MiB installed.
// Stall: when rsp_tready is low the result register holds; the input
// register fills behind it and req_tready drops only once both are full.
module dram_bank_address_remap_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [dbar_pkg::AddrWidth-1:0]       req_tdata,   // [23:0] cpu_address
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [dbar_pkg::RspDataWidth-1:0]    rsp_tdata,   // [21:0] mapped_address, [23:22] 0
   output logic [1:0]                           rsp_tuser,   // [1:0] map_status
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dbar_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [dbar_pkg::CsrDataWidth-1:0]    csr_data
);
   import dbar_pkg::*;

   cfg_type                 cfg;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic [AddrWidth-1:0]    in_addr_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [MapWidth-1:0]     out_addr_ff;
   status_type              out_status_ff;
   logic [MapWidth-1:0]     calc_addr;
   status_type              calc_status;
   logic                    out_ready;
   logic                    in_ready;

   dbar_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dbar_remap u_remap (
      .cpu_address    (in_addr_ff),
      .cfg            (cfg),
      .mapped_address (calc_addr),
      .map_status     (calc_status)
   );

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   assign in_valid_in  = in_ready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) begin
         in_addr_ff <= req_tdata;
      end
      if (out_ready && in_valid_ff) begin
         out_addr_ff   <= calc_addr;
         out_status_ff <= calc_status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-MapWidth){1'b0}}, out_addr_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

### verif/dbar_remap_checker.sv
// Checker for the DRAM bank address remap block: watches the req_, rsp_ and csr_ channels,
// predicts each result from its own copy of the registers and compares field by field.
// Depends on dbar_pkg.
`timescale 1ns / 1ps

module dbar_remap_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [dbar_pkg::AddrWidth-1:0]      req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [dbar_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic [1:0]                          rsp_tuser,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dbar_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [dbar_pkg::CsrDataWidth-1:0]   csr_data,
   output int unsigned                         in_flight,
   output int unsigned                         mismatches
);
   import dbar_pkg::*;

   typedef struct packed {
      logic [MapWidth-1:0] mapped_address;
      status_type          map_status;
   } remap_result_type;

   size_type                ctrl0, ctrl1, ram0, ram1;
   logic                    early_decode;
   logic [OffsetWidth-1:0]  installed;
   remap_result_type        pending_remaps[$];

   initial mismatches = 0;
   initial in_flight = 0;

   function automatic logic [OffsetWidth-1:0] bank_bytes(input size_type code);
      case (code)
         SIZE_128K: return 23'h02_0000;
         SIZE_512K: return 23'h08_0000;
         SIZE_2M:   return 23'h20_0000;
         default:   return '0;
      endcase
   endfunction

   function automatic logic [OffsetWidth-1:0] dead_lines(input size_type ctrl,
                                                         input size_type ram,
                                                         input logic early);
      logic [OffsetWidth-1:0] lines;
      lines = '0;
      case (ctrl)
         SIZE_2M: begin
            if (ram == SIZE_512K)
               lines = early ? 23'h10_0400 : 23'h18_0000;
            else if (ram == SIZE_128K)
               lines = early ? 23'h18_0600 : 23'h1E_0000;
         end
         SIZE_512K: begin
            if (ram == SIZE_128K)
               lines = early ? 23'h04_0200 : 23'h06_0000;
         end
         default: lines = '0;
      endcase
      return lines;
   endfunction

   function automatic remap_result_type predict_remap(input logic [AddrWidth-1:0] cpu_address);
      logic [AddrWidth-1:0] offset;
      size_type             ctrl, ram;
      logic                 upper;
      remap_result_type     r;
      offset = cpu_address;
      ctrl = ctrl0;
      ram = ram0;
      upper = 1'b0;
      r.map_status = STATUS_OK;
      r.mapped_address = '0;
      if (cpu_address > WindowTop) begin
         r.map_status = STATUS_BUS_ERR;
      end else begin
         if (offset >= bank_bytes(ctrl0)) begin
            upper = 1'b1;
            offset = offset - bank_bytes(ctrl0);
            ctrl = ctrl1;
            ram = ram1;
            if (offset >= bank_bytes(ctrl1))
               r.map_status = STATUS_GAP;
         end
         if (r.map_status == STATUS_OK && bank_bytes(ram) == '0)
            r.map_status = STATUS_GAP;
         if (r.map_status == STATUS_OK) begin
            offset = offset & ~{1'b0, dead_lines(ctrl, ram, early_decode)};
            if (upper)
               offset = offset + bank_bytes(ram0);
            if (offset >= installed)
               r.map_status = STATUS_PAST;
         end
      end
      if (r.map_status == STATUS_OK)
         r.mapped_address = offset[MapWidth-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: remap mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      remap_result_type want;
      if (reset) begin
         ctrl0 <= SIZE_2M;
         ctrl1 <= SIZE_2M;
         ram0 <= SIZE_2M;
         ram1 <= SIZE_2M;
         early_decode <= 1'b1;
         installed <= InstalledRst;
         pending_remaps.delete();
         in_flight <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_CTRL_BANK0: ctrl0 <= size_type'(csr_data[1:0]);
               CSR_CTRL_BANK1: ctrl1 <= size_type'(csr_data[1:0]);
               CSR_RAM_BANK0:  ram0 <= size_type'(csr_data[1:0]);
               CSR_RAM_BANK1:  ram1 <= size_type'(csr_data[1:0]);
               CSR_EARLY:      early_decode <= csr_data[0];
               CSR_INSTALLED:  installed <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_remaps.push_back(predict_remap(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_remaps.size() == 0) begin
               report_mismatch($sformatf("result %0h/%0d with nothing pending",
                                         rsp_tdata, rsp_tuser));
            end else begin
               want = pending_remaps.pop_front();
               if (rsp_tuser != want.map_status)
                  report_mismatch($sformatf("map_status expected %0d got %0d",
                                            want.map_status, rsp_tuser));
               if (rsp_tdata[MapWidth-1:0] != want.mapped_address)
                  report_mismatch($sformatf("mapped_address expected %0h got %0h",
                                            want.mapped_address, rsp_tdata[MapWidth-1:0]));
            end
         end
         in_flight <= pending_remaps.size();
      end
   end

endmodule

### verif/tb.sv
// Testbench top for dram_bank_address_remap_top: drives addresses and register
// writes with random idling and stalls; dbar_remap_checker predicts and compares.
// Depends on dbar_pkg, the block and verif/dbar_remap_checker.sv.
`timescale 1ns / 1ps

module tb;
   import dbar_pkg::*;

   localparam int Phases        = 14;
   localparam int ItemsPerPhase = 135;
   localparam int LongHold      = 48;
   localparam int SettleCycles  = 4;
   localparam int WatchdogLimit = 1000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [AddrWidth-1:0]      req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]   rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CsrIndexWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0]   csr_data = '0;
   int unsigned               in_flight;
   int unsigned               mismatches;
   int unsigned               idle_cycles = 0;
   bit                        calm = 1'b0;
   bit                        hold_long = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   dram_bank_address_remap_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   dbar_remap_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .in_flight  (in_flight),
      .mismatches (mismatches)
   );

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("dram_bank_address_remap_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : drain_results
      int unsigned pause;
      while (reset) @(posedge clock);
      forever begin
         pause = calm ? 0 : $urandom_range(0, 7);
         if (hold_long) begin
            pause = LongHold;
            hold_long = 1'b0;
         end
         if (pause != 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   function automatic cfg_type make_cfg(input size_type c0, input size_type c1,
                                        input size_type r0, input size_type r1,
                                        input logic early,
                                        input logic [OffsetWidth-1:0] bytes);
      cfg_type c;
      c.ctrl_bank0_size = c0;
      c.ctrl_bank1_size = c1;
      c.ram_bank0_size = r0;
      c.ram_bank1_size = r1;
      c.early_model_decoding = early;
      c.installed_bytes = bytes;
      return c;
   endfunction

   function automatic logic [AddrWidth-1:0] pick_address();
      logic [AddrWidth-1:0] corners [10] = '{24'h02_0000, 24'h04_0000, 24'h08_0000,
                                              24'h0A_0000, 24'h10_0000, 24'h20_0000,
                                              24'h22_0000, 24'h28_0000, 24'h30_0000,
                                              24'h40_0000};
      int unsigned kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1:    return AddrWidth'($urandom());
         2:       return AddrWidth'(WindowTop - 2 + $urandom_range(0, 3));
         3, 4:    return AddrWidth'(corners[$urandom_range(0, 9)] - 2
                                    + $urandom_range(0, 3));
         default: return AddrWidth'($urandom_range(0, 24'h40_0000));
      endcase
   endfunction

   task automatic send_address(input logic [AddrWidth-1:0] cpu_address);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cpu_address;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Hold csr_valid high across the writes; drop it in program_regs.
   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      write_reg(CSR_CTRL_BANK0, CsrDataWidth'(c.ctrl_bank0_size));
      write_reg(CSR_CTRL_BANK1, CsrDataWidth'(c.ctrl_bank1_size));
      write_reg(CSR_RAM_BANK0, CsrDataWidth'(c.ram_bank0_size));
      write_reg(CSR_RAM_BANK1, CsrDataWidth'(c.ram_bank1_size));
      write_reg(CSR_EARLY, CsrDataWidth'(c.early_model_decoding));
      write_reg(CSR_INSTALLED, c.installed_bytes);
      csr_valid <= 1'b0;
   endtask

   task automatic send_list(input logic [AddrWidth-1:0] addrs[$]);
      foreach (addrs[i])
         send_address(addrs[i]);
   endtask

   initial begin : stimulus
      cfg_type c;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: window edges and bus errors
      send_list('{24'h00_0000, 24'h1F_FFFF, 24'h20_0000, 24'h3F_FFFF, 24'h40_0000,
                  24'h40_0001, 24'hFF_FFFF, 24'hFF_FFFE, 24'h80_0000});
      wait_idle();
      program_regs(make_cfg(SIZE_2M, SIZE_2M, SIZE_512K, SIZE_128K, 1'b1, InstalledRst));
      send_list('{24'h1F_FFFF, 24'h10_0400, 24'h3F_FFFF, 24'h30_0600});
      wait_idle();
      program_regs(make_cfg(SIZE_2M, SIZE_2M, SIZE_512K, SIZE_128K, 1'b0, InstalledRst));
      send_list('{24'h1F_FFFF, 24'h3F_FFFF, 24'h1A_0000});
      wait_idle();
      // empty bank 0, bank 1 past installed and beyond the controller bank
      program_regs(make_cfg(SIZE_128K, SIZE_512K, SIZE_NONE, SIZE_128K, 1'b1, 23'h03_0000));
      send_list('{24'h00_0000, 24'h01_FFFF, 24'h02_0000, 24'h09_FFFF, 24'h0A_0000});
      wait_idle();
      program_regs(make_cfg(SIZE_NONE, SIZE_NONE, SIZE_2M, SIZE_2M, 1'b0, '0));
      send_list('{24'h00_0000, 24'h40_0000});
      wait_idle();

      for (int phase = 0; phase < Phases; phase++) begin
         case (phase)
            0: c = make_cfg(SIZE_NONE, SIZE_NONE, SIZE_NONE, SIZE_NONE, 1'b1, InstalledRst);
            1: c = make_cfg(SIZE_128K, SIZE_128K, SIZE_128K, SIZE_128K, 1'b0, '0);
            2: c = make_cfg(SIZE_2M, SIZE_2M, SIZE_128K, SIZE_128K, 1'b0, InstalledRst);
            3: c = make_cfg(SIZE_2M, SIZE_2M, SIZE_2M, SIZE_2M, 1'b1, 23'h3F_FFFF);
            default: begin
               c = make_cfg(size_type'($urandom_range(0, 3)), size_type'($urandom_range(0, 3)),
                            size_type'($urandom_range(0, 3)), size_type'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)),
                            ($urandom_range(0, 3) == 0) ? InstalledRst
                                                        : 23'($urandom_range(0, 4194304)));
            end
         endcase
         program_regs(c);
         calm = (phase % 4 == 3) || (phase == 5);
         if (phase == 5)
            hold_long = 1'b1;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (phase == 7 && n == ItemsPerPhase / 2)
               wait_idle();
            send_address(pick_address());
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("dram_bank_address_remap_top verification clean");
      else
         $display("dram_bank_address_remap_top verification failed");
      $finish;
   end

endmodule

### filelist.f
rtl/dbar_pkg.sv
rtl/dbar_csr.sv
rtl/dbar_remap.sv
rtl/dram_bank_address_remap_top.sv
verif/dbar_remap_checker.sv
verif/tb.sv
